// ===== hdl/keyframe_linear_interpolator_macros.svh =====
// Assertion macros for the keyframe linear interpolator.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define KLI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyframe interpolator check failed");
`define KLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyframe interpolator check failed");
`else
`define KLI_ASSERT_SAME(label, ante, cons)
`define KLI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/kfli_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe interpolator package
// Shared constants, command and status codes and the lane control type.
// ---------------------------------------------------------------------------
package kfli_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int DATA_W   = 32;
    localparam int STEPS_W  = 16;
    localparam int MAG_W    = DATA_W + 1;
    localparam int DCNT_W   = $clog2(MAG_W + 1);

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_MODIFY = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_START  = 3'd4,
        CMD_STOP   = 3'd5,
        CMD_SET    = 3'd6,
        CMD_NONE   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FEW   = 2'd3
    } status_t;

    typedef struct packed {
        logic              wr_en;
        logic [KEY_AW-1:0] wr_addr;
        logic [KEY_AW-1:0] rd_addr;
        logic              load_base;
        logic              load_pose;
        logic              div_start;
        logic              tick_add;
        logic              set_pose;
        logic              load_step;
    } lane_ctl_t;

endpackage

// ===== hdl/kfli_lane.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe interpolator axis lane
// Key memory, increment divider, increment and saturating pose of one axis.
// ---------------------------------------------------------------------------
module kfli_lane
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  kfli_pkg::lane_ctl_t                   ctl,
    input  logic signed [kfli_pkg::DATA_W-1:0]    key_in,
    input  logic [kfli_pkg::STEPS_W-1:0]          divisor,
    output logic signed [kfli_pkg::DATA_W-1:0]    pose,
    output logic                                  busy
);

    logic [kfli_pkg::DATA_W-1:0]         mem [kfli_pkg::MAX_KEYS];
    logic [kfli_pkg::DATA_W-1:0]         rd_reg;
    logic [kfli_pkg::DATA_W-1:0]         base_reg;
    logic [kfli_pkg::MAG_W-1:0]          num_reg;
    logic [kfli_pkg::MAG_W-1:0]          num_next;
    logic [kfli_pkg::STEPS_W-1:0]        rem_reg;
    logic [kfli_pkg::STEPS_W-1:0]        rem_next;
    logic                                sign_reg;
    logic [kfli_pkg::DCNT_W-1:0]         cnt_reg;
    logic                                busy_reg;
    logic signed [kfli_pkg::DATA_W-1:0]  pose_reg;
    logic signed [kfli_pkg::DATA_W-1:0]  pose_next;
    logic signed [kfli_pkg::DATA_W-1:0]  step_reg;
    logic signed [kfli_pkg::DATA_W-1:0]  step_next;
    logic [kfli_pkg::MAG_W-1:0]          diff;
    logic [kfli_pkg::MAG_W-1:0]          mag;
    logic [kfli_pkg::STEPS_W:0]          trial;
    logic [kfli_pkg::STEPS_W:0]          trial_sub;
    logic [kfli_pkg::DATA_W:0]           sum;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= key_in;
        end
        rd_reg <= mem[ctl.rd_addr];
    end

    assign diff  = {rd_reg[kfli_pkg::DATA_W-1], rd_reg} - {base_reg[kfli_pkg::DATA_W-1], base_reg};
    assign mag   = diff[kfli_pkg::MAG_W-1] ? (~diff + 1'b1) : diff;
    assign trial = {rem_reg, num_reg[kfli_pkg::MAG_W-1]};
    assign trial_sub = trial - {1'b0, divisor};

    always_comb
    begin
        if (!trial_sub[kfli_pkg::STEPS_W])
        begin
            rem_next = trial_sub[kfli_pkg::STEPS_W-1:0];
            num_next = {num_reg[kfli_pkg::MAG_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[kfli_pkg::STEPS_W-1:0];
            num_next = {num_reg[kfli_pkg::MAG_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        if (!sign_reg)
        begin
            if (num_reg > {1'b0, 1'b0, {(kfli_pkg::DATA_W-1){1'b1}}})
                step_next = {1'b0, {(kfli_pkg::DATA_W-1){1'b1}}};
            else
                step_next = num_reg[kfli_pkg::DATA_W-1:0];
        end
        else
        begin
            if (num_reg > {1'b0, 1'b1, {(kfli_pkg::DATA_W-1){1'b0}}})
                step_next = {1'b1, {(kfli_pkg::DATA_W-1){1'b0}}};
            else
                step_next = ~num_reg[kfli_pkg::DATA_W-1:0] + 1'b1;
        end
    end

    assign sum = {pose_reg[kfli_pkg::DATA_W-1], pose_reg} + {step_reg[kfli_pkg::DATA_W-1], step_reg};

    always_comb
    begin
        pose_next = pose_reg;
        if (ctl.set_pose)
        begin
            pose_next = key_in;
        end
        else if (ctl.load_base && ctl.load_pose)
        begin
            pose_next = rd_reg;
        end
        else if (ctl.tick_add)
        begin
            if (sum[kfli_pkg::DATA_W] != sum[kfli_pkg::DATA_W-1])
                pose_next = sum[kfli_pkg::DATA_W] ? {1'b1, {(kfli_pkg::DATA_W-1){1'b0}}}
                                                  : {1'b0, {(kfli_pkg::DATA_W-1){1'b1}}};
            else
                pose_next = sum[kfli_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_base)
        begin
            base_reg <= rd_reg;
        end
        if (ctl.div_start)
        begin
            sign_reg <= diff[kfli_pkg::MAG_W-1];
            num_reg  <= mag;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            pose_reg <= pose_next;
            if (ctl.load_step)
            begin
                step_reg <= step_next;
            end
            if (ctl.div_start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= kfli_pkg::DCNT_W'(kfli_pkg::MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == kfli_pkg::DCNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign pose = pose_reg;
    assign busy = busy_reg;

endmodule

// ===== hdl/keyframe_linear_interpolator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe linear interpolator
// Keyframe table with playback by per-axis linear steps.
// ---------------------------------------------------------------------------
// Usage:
//   Input transaction: in_valid/in_stall with cmd, key_x, key_y, key_angle.
//   Output transaction: out_valid/out_stall carries pose, playback state,
//   finished and status; exactly one output per input.
//   Config: cfg_valid/cfg_ready writes steps_per_segment (always ready).
// Sequencing:
//   Table edits, stop, set pose and plain ticks: output in the cycle after accept.
//   Start and segment advance: memory reads in S_RD0, S_RD1 and S_RD2, the
//   bit-serial divider (one quotient bit per cycle in each axis lane),
//   then the increments load and the output is registered.
//   The three axis lanes divide in parallel; the next transaction is taken
//   once the previous one has finished its work.
// Reset: table empty, pose and increments zero, playback stopped, steps 60.
// Receiver stall: output holds, and no new input is taken until the
//   pending output is taken or the same edge takes it.
// ---------------------------------------------------------------------------
`include "keyframe_linear_interpolator_macros.svh"

module keyframe_linear_interpolator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           cmd,
    input  logic signed [31:0]                   key_x,
    input  logic signed [31:0]                   key_y,
    input  logic signed [31:0]                   key_angle,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [31:0]                   pos_x,
    output logic signed [31:0]                   pos_y,
    output logic signed [31:0]                   pos_angle,
    output logic                                 is_playing,
    output logic [5:0]                           segment,
    output logic [6:0]                           key_count,
    output logic                                 finished,
    output logic [1:0]                           status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [15:0]                          cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD0  = 5'b00010,
        S_RD1  = 5'b00100,
        S_RD2  = 5'b01000,
        S_DIV  = 5'b10000
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    logic [kfli_pkg::CNT_W-1:0]           stored_reg;
    logic [kfli_pkg::CNT_W-1:0]           stored_next;
    logic [kfli_pkg::KEY_AW-1:0]          seg_reg;
    logic [kfli_pkg::KEY_AW-1:0]          seg_next;
    logic [kfli_pkg::STEPS_W-1:0]         tick_reg;
    logic [kfli_pkg::STEPS_W-1:0]         tick_next;
    logic                                 running_reg;
    logic                                 running_next;
    logic [kfli_pkg::STEPS_W-1:0]         steps_reg;
    logic                                 load_pose_reg;
    logic                                 load_pose_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic                                 fin_reg;
    logic                                 fin_next;
    kfli_pkg::status_t                    status_reg;
    kfli_pkg::status_t                    status_next;
    kfli_pkg::lane_ctl_t                  ctl;
    logic                                 accept;
    logic [kfli_pkg::STEPS_W-1:0]         eff_steps;
    logic [kfli_pkg::CNT_W:0]             seg_limit;
    logic [2:0]                           lane_busy;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign cfg_ready = 1'b1;
    assign eff_steps = (steps_reg == '0) ? kfli_pkg::STEPS_W'(1) : steps_reg;
    assign seg_limit = {2'b00, seg_reg} + (kfli_pkg::CNT_W + 1)'(3);

    always_comb
    begin
        state_next     = state_reg;
        stored_next    = stored_reg;
        seg_next       = seg_reg;
        tick_next      = tick_reg;
        running_next   = running_reg;
        load_pose_next = load_pose_reg;
        fin_next       = fin_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctl            = '0;
        ctl.rd_addr    = seg_reg;
        ctl.wr_addr    = stored_reg[kfli_pkg::KEY_AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fin_next       = 1'b0;
                    status_next    = kfli_pkg::ST_OK;
                    out_valid_next = 1'b1;
                    case (kfli_pkg::cmd_t'(cmd))
                        kfli_pkg::CMD_TICK:
                        begin
                            if (running_reg)
                            begin
                                if (tick_reg >= eff_steps)
                                begin
                                    if (seg_limit > {1'b0, stored_reg})
                                    begin
                                        seg_next     = '0;
                                        running_next = 1'b0;
                                        fin_next     = 1'b1;
                                    end
                                    else
                                    begin
                                        seg_next       = seg_reg + 1'b1;
                                        tick_next      = '0;
                                        load_pose_next = 1'b0;
                                        out_valid_next = 1'b0;
                                        state_next     = S_RD0;
                                    end
                                end
                                else
                                begin
                                    ctl.tick_add = 1'b1;
                                    tick_next    = tick_reg + 1'b1;
                                end
                            end
                        end
                        kfli_pkg::CMD_APPEND:
                        begin
                            if (stored_reg >= kfli_pkg::CNT_W'(kfli_pkg::MAX_KEYS))
                            begin
                                status_next = kfli_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.wr_en   = 1'b1;
                                stored_next = stored_reg + 1'b1;
                            end
                        end
                        kfli_pkg::CMD_MODIFY:
                        begin
                            if (stored_reg == '0)
                            begin
                                status_next = kfli_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_addr = kfli_pkg::KEY_AW'(stored_reg - 1'b1);
                            end
                        end
                        kfli_pkg::CMD_DELETE:
                        begin
                            if (stored_reg == '0)
                                status_next = kfli_pkg::ST_EMPTY;
                            else
                                stored_next = stored_reg - 1'b1;
                        end
                        kfli_pkg::CMD_START:
                        begin
                            if (stored_reg < kfli_pkg::CNT_W'(2))
                            begin
                                status_next = kfli_pkg::ST_FEW;
                            end
                            else
                            begin
                                seg_next       = '0;
                                tick_next      = '0;
                                running_next   = 1'b1;
                                load_pose_next = 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = S_RD0;
                            end
                        end
                        kfli_pkg::CMD_STOP:
                        begin
                            running_next = 1'b0;
                            seg_next     = '0;
                            tick_next    = '0;
                        end
                        kfli_pkg::CMD_SET:
                        begin
                            ctl.set_pose = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                ctl.rd_addr   = seg_reg + 1'b1;
                ctl.load_base = 1'b1;
                ctl.load_pose = load_pose_reg;
                state_next    = S_RD2;
            end
            S_RD2:
            begin
                ctl.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (lane_busy == '0)
                begin
                    ctl.load_step  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stored_reg    <= '0;
            seg_reg       <= '0;
            tick_reg      <= '0;
            running_reg   <= 1'b0;
            steps_reg     <= kfli_pkg::STEPS_W'(60);
            load_pose_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fin_reg       <= 1'b0;
            status_reg    <= kfli_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            stored_reg    <= stored_next;
            seg_reg       <= seg_next;
            tick_reg      <= tick_next;
            running_reg   <= running_next;
            load_pose_reg <= load_pose_next;
            out_valid_reg <= out_valid_next;
            fin_reg       <= fin_next;
            status_reg    <= status_next;
            if (cfg_valid && cfg_ready)
            begin
                steps_reg <= cfg_data;
            end
        end
    end

    kfli_lane u_lane_x
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .key_in  (key_x),
        .divisor (eff_steps),
        .pose    (pos_x),
        .busy    (lane_busy[0])
    );

    kfli_lane u_lane_y
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .key_in  (key_y),
        .divisor (eff_steps),
        .pose    (pos_y),
        .busy    (lane_busy[1])
    );

    kfli_lane u_lane_angle
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .key_in  (key_angle),
        .divisor (eff_steps),
        .pose    (pos_angle),
        .busy    (lane_busy[2])
    );

    assign out_valid  = out_valid_reg;
    assign is_playing = running_reg;
    assign segment    = seg_reg;
    assign key_count  = stored_reg;
    assign finished   = fin_reg;
    assign status     = status_reg;

    `KLI_ASSERT_SAME(a_count_range, 1'b1, stored_reg <= kfli_pkg::CNT_W'(kfli_pkg::MAX_KEYS))
    `KLI_ASSERT_SAME(a_lanes_agree, 1'b1, lane_busy == '0 || lane_busy == 3'b111)
    `KLI_ASSERT_SAME(a_no_out_in_work, state_reg != S_IDLE, !out_valid_reg)
    `KLI_ASSERT_NEXT(a_play_when_loading, state_reg == S_RD0, running_reg && state_reg == S_RD1)

endmodule

// ===== verif/keyframe_linear_interpolator_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe linear interpolator testbench
// Drives command transactions into the interpolator, predicts every output
// transaction with an independent model of the keyframe table and playback,
// and compares all fields in order. Covers table edits at empty and full,
// start with too few keys, saturating increments and pose, segment advance
// and end of playback, under random idling and long output stalls.
// ---------------------------------------------------------------------------

typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pa;
    logic               playing;
    logic [5:0]         seg;
    logic [6:0]         count;
    logic               fin;
    kfli_pkg::status_t  st;
} pose_rec_t;

class pose_scoreboard;
    logic signed [31:0] tab_x[kfli_pkg::MAX_KEYS];
    logic signed [31:0] tab_y[kfli_pkg::MAX_KEYS];
    logic signed [31:0] tab_a[kfli_pkg::MAX_KEYS];
    int                 keys;
    logic signed [31:0] inc_x, inc_y, inc_a;
    logic signed [31:0] cur_x, cur_y, cur_a;
    int                 seg;
    int                 ticks;
    bit                 playing;
    int                 steps;
    pose_rec_t          pending[$];
    int                 errors;

    function new();
        keys = 0; inc_x = 0; inc_y = 0; inc_a = 0;
        cur_x = 0; cur_y = 0; cur_a = 0;
        seg = 0; ticks = 0; playing = 0; steps = 60; errors = 0;
    endfunction

    function logic signed [31:0] clamp(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function int div_steps();
        return (steps == 0) ? 1 : steps;
    endfunction

    function void load_inc(int s);
        longint d;
        d = div_steps();
        if (s + 1 >= keys || s + 1 >= kfli_pkg::MAX_KEYS) return;
        inc_x = clamp((longint'(tab_x[s+1]) - longint'(tab_x[s])) / d);
        inc_y = clamp((longint'(tab_y[s+1]) - longint'(tab_y[s])) / d);
        inc_a = clamp((longint'(tab_a[s+1]) - longint'(tab_a[s])) / d);
    endfunction

    function void note_command(kfli_pkg::cmd_t c, logic signed [31:0] kx,
                               logic signed [31:0] ky, logic signed [31:0] ka);
        pose_rec_t r;
        r.fin = 0;
        r.st = kfli_pkg::ST_OK;
        case (c)
            kfli_pkg::CMD_TICK:
                if (playing)
                begin
                    if (ticks >= div_steps())
                    begin
                        seg++;
                        if (seg > keys - 2)
                        begin
                            seg = 0; playing = 0; r.fin = 1;
                        end
                        else
                        begin
                            ticks = 0; load_inc(seg);
                        end
                    end
                    else
                    begin
                        cur_x = clamp(longint'(cur_x) + longint'(inc_x));
                        cur_y = clamp(longint'(cur_y) + longint'(inc_y));
                        cur_a = clamp(longint'(cur_a) + longint'(inc_a));
                        ticks = (ticks + 1) & 16'hffff;
                    end
                end
            kfli_pkg::CMD_APPEND:
                if (keys >= kfli_pkg::MAX_KEYS) r.st = kfli_pkg::ST_FULL;
                else
                begin
                    tab_x[keys] = kx; tab_y[keys] = ky; tab_a[keys] = ka; keys++;
                end
            kfli_pkg::CMD_MODIFY:
                if (keys == 0) r.st = kfli_pkg::ST_EMPTY;
                else
                begin
                    tab_x[keys-1] = kx; tab_y[keys-1] = ky; tab_a[keys-1] = ka;
                end
            kfli_pkg::CMD_DELETE:
                if (keys == 0) r.st = kfli_pkg::ST_EMPTY;
                else keys--;
            kfli_pkg::CMD_START:
                if (keys < 2) r.st = kfli_pkg::ST_FEW;
                else
                begin
                    cur_x = tab_x[0]; cur_y = tab_y[0]; cur_a = tab_a[0];
                    seg = 0; ticks = 0; load_inc(0); playing = 1;
                end
            kfli_pkg::CMD_STOP:
            begin
                playing = 0; seg = 0; ticks = 0;
            end
            kfli_pkg::CMD_SET:
            begin
                cur_x = kx; cur_y = ky; cur_a = ka;
            end
            default: ;
        endcase
        r.px = cur_x; r.py = cur_y; r.pa = cur_a;
        r.playing = playing; r.seg = seg[5:0]; r.count = keys[6:0];
        pending = {pending, r};
    endfunction

    function void check_pose(pose_rec_t got);
        pose_rec_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: output transaction with none expected: %p", $time, got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.px !== e.px)
            $display("%0t: pos_x expected %h actual %h", $time, e.px, got.px);
        if (got.py !== e.py)
            $display("%0t: pos_y expected %h actual %h", $time, e.py, got.py);
        if (got.pa !== e.pa)
            $display("%0t: pos_angle expected %h actual %h", $time, e.pa, got.pa);
        if (got.playing !== e.playing)
            $display("%0t: is_playing expected %b actual %b", $time, e.playing, got.playing);
        if (got.seg !== e.seg)
            $display("%0t: segment expected %0d actual %0d", $time, e.seg, got.seg);
        if (got.count !== e.count)
            $display("%0t: key_count expected %0d actual %0d", $time, e.count, got.count);
        if (got.fin !== e.fin)
            $display("%0t: finished expected %b actual %b", $time, e.fin, got.fin);
        if (got.st !== e.st)
            $display("%0t: status expected %0d actual %0d", $time, e.st, got.st);
        if (got !== e) errors++;
    endfunction
endclass

module keyframe_linear_interpolator_test;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         cmd;
    logic signed [31:0] key_x, key_y, key_angle;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] pos_x, pos_y, pos_angle;
    logic               is_playing;
    logic [5:0]         segment;
    logic [6:0]         key_count;
    logic               finished;
    logic [1:0]         status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;

    pose_scoreboard     board;
    int                 idle_pct_in;
    int                 idle_pct_out;
    bit                 hold_output;
    int                 quiet_cycles;
    int                 sent;

    keyframe_linear_interpolator u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .key_x(key_x), .key_y(key_y), .key_angle(key_angle),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_angle(pos_angle),
        .is_playing(is_playing), .segment(segment), .key_count(key_count),
        .finished(finished), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // output side: random stall, checks on accept
    always @(posedge clk)
    begin
        pose_rec_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pos_x, pos_y, pos_angle, is_playing, segment, key_count, finished,
                   kfli_pkg::status_t'(status)};
            board.check_pose(got);
        end
        if (hold_output)
            out_stall <= 1;
        else
            out_stall <= ($urandom_range(99) < idle_pct_out);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("keyframe_linear_interpolator test failed");
            $finish;
        end
    end

    task automatic send(kfli_pkg::cmd_t c, logic signed [31:0] x, logic signed [31:0] y,
                        logic signed [31:0] a);
        while ($urandom_range(99) < idle_pct_in)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid  <= 1;
        cmd       <= c;
        key_x     <= x;
        key_y     <= y;
        key_angle <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_command(c, x, y, a);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_steps(logic [15:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.steps = v;
        cfg_valid <= 0;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_key(kfli_pkg::cmd_t c);
        send(c, rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic play_run(int nkeys, int extra);
        int k;
        int n;
        send(kfli_pkg::CMD_STOP, 0, 0, 0);
        while (board.keys > 0) send(kfli_pkg::CMD_DELETE, 0, 0, 0);
        for (k = 0; k < nkeys; k++) random_key(kfli_pkg::CMD_APPEND);
        send(kfli_pkg::CMD_START, 0, 0, 0);
        n = (nkeys - 1) * (board.div_steps() + 1) + extra;
        if (n > 200) n = 200;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(29))
                0: random_key(kfli_pkg::CMD_APPEND);
                1: random_key(kfli_pkg::CMD_MODIFY);
                2: send(kfli_pkg::CMD_DELETE, 0, 0, 0);
                3: random_key(kfli_pkg::CMD_SET);
                4: send(kfli_pkg::CMD_START, 0, 0, 0);
                5: send(kfli_pkg::cmd_t'($urandom_range(7)), $urandom, $urandom, $urandom);
                default: send(kfli_pkg::CMD_TICK, $urandom, $urandom, $urandom);
            endcase
        end
    endtask

    initial
    begin
        int k;
        board        = new();
        rst_n        = 0;
        in_valid     = 0;
        cmd          = kfli_pkg::CMD_TICK;
        key_x        = 0;
        key_y        = 0;
        key_angle    = 0;
        out_stall    = 0;
        cfg_valid    = 0;
        cfg_data     = 0;
        idle_pct_in  = 0;
        idle_pct_out = 0;
        hold_output  = 0;
        sent         = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        send(kfli_pkg::CMD_TICK, 0, 0, 0);
        send(kfli_pkg::CMD_MODIFY, 1, 2, 3);
        send(kfli_pkg::CMD_DELETE, 0, 0, 0);
        send(kfli_pkg::CMD_START, 0, 0, 0);
        send(kfli_pkg::CMD_APPEND, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send(kfli_pkg::CMD_START, 0, 0, 0);
        send(kfli_pkg::CMD_APPEND, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send(kfli_pkg::CMD_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        write_steps(1);
        send(kfli_pkg::CMD_START, 0, 0, 0);
        for (k = 0; k < 4; k++) send(kfli_pkg::CMD_TICK, 0, 0, 0);
        send(kfli_pkg::CMD_SET, 32'sh7ffffff0, -32'sh7ffffff0, 5);
        send(kfli_pkg::CMD_START, 0, 0, 0);
        send(kfli_pkg::CMD_TICK, 0, 0, 0);
        send(kfli_pkg::CMD_STOP, 0, 0, 0);
        write_steps(0);
        send(kfli_pkg::CMD_START, 0, 0, 0);
        send(kfli_pkg::CMD_TICK, 0, 0, 0);

        // fill to full, then overflow
        while (board.keys < kfli_pkg::MAX_KEYS) random_key(kfli_pkg::CMD_APPEND);
        random_key(kfli_pkg::CMD_APPEND);
        random_key(kfli_pkg::CMD_MODIFY);

        // long receiver hold while sender keeps offering
        idle_pct_in = 20;
        hold_output = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_output = 0;
            end
            for (k = 0; k < 30; k++) send(kfli_pkg::CMD_TICK, 0, 0, 0);
        join
        drain();

        // random phases under varied step counts
        write_steps(16'hffff);
        play_run(2, 3);
        write_steps(3);
        idle_pct_out = 20;
        play_run(5, 10);
        idle_pct_in  = 0;
        idle_pct_out = 0;
        play_run(6, 5);
        idle_pct_in  = 20;
        idle_pct_out = 20;
        write_steps(1);
        play_run(kfli_pkg::MAX_KEYS, 20);
        write_steps(7);
        while (sent < 1700) play_run($urandom_range(2, 8), $urandom_range(10));
        write_steps(60);
        play_run(2, 5);

        drain();
        if (board.errors == 0)
            $display("keyframe_linear_interpolator test passed");
        else
            $display("keyframe_linear_interpolator test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/kfli_pkg.sv
hdl/kfli_lane.sv
hdl/keyframe_linear_interpolator.sv
verif/keyframe_linear_interpolator_test.sv
